// ===== rtl/sfc_pkg.sv =====
// Constants and types shared by the sensor frame checksum parser.
package sfc_pkg;

  localparam logic [7:0] START_BYTE  = 8'hFF;
  localparam logic [7:0] TYPE_ANSWER = 8'h86;
  localparam logic [7:0] TYPE_UPLOAD = 8'h04;

  localparam logic [3:0] POS_HUNT       = 4'd0;
  localparam logic [3:0] POS_TYPE       = 4'd1;
  localparam logic [3:0] POS_FIRST_DATA = 4'd2;
  localparam logic [3:0] POS_LAST_DATA  = 4'd5;
  localparam logic [3:0] FRAME_LAST     = 4'd8;

  localparam int PAYLOAD_DEPTH = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_BAD_SUM  = 2'd2
  } status_t;

endpackage

// ===== rtl/sensor_frame_checksum_parser.sv =====
// Top level of the sensor frame checksum parser with its frame state and result register.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   rx_byte [7:0]
//   out      out_valid / out_ready status [1:0], concentration [15:0], active_upload
//
// One input beat is taken per cycle; the frame counter, running sum and payload bytes
// update in the same cycle. The ninth byte of a frame loads the result register, so a
// result is valid in the cycle after its last byte. Reset clears the counter, sum, type and
// result valid. A result that waits for out_ready holds off every input beat until it is taken.
module sensor_frame_checksum_parser
  import sfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] concentration,
  output logic        active_upload
);

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] frame_type;
  logic [7:0] payload [PAYLOAD_DEPTH];

  logic       in_fire;
  logic       hunting;
  logic       at_last;
  logic       emit;
  status_t    status_next;
  logic [15:0] conc_next;
  logic       upload_next;
  logic [1:0] pay_idx;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign hunting  = (pos == POS_HUNT) || (pos > FRAME_LAST);
  assign at_last  = (pos == FRAME_LAST);
  assign emit     = in_fire && at_last;
  assign pay_idx  = 2'(pos - POS_FIRST_DATA);

  always_comb begin
    pos_next         = pos;
    running_sum_next = running_sum;
    if (hunting) begin
      pos_next         = (rx_byte == START_BYTE) ? POS_TYPE : POS_HUNT;
      running_sum_next = (rx_byte == START_BYTE) ? 8'd0 : running_sum;
    end else if (at_last) begin
      pos_next         = POS_HUNT;
      running_sum_next = 8'd0;
    end else begin
      pos_next         = 4'(pos + 4'd1);
      running_sum_next = 8'(running_sum + rx_byte);
    end
  end

  always_comb begin
    status_next = ST_OK;
    conc_next   = 16'd0;
    upload_next = 1'b0;
    if (frame_type != TYPE_ANSWER && frame_type != TYPE_UPLOAD) begin
      status_next = ST_BAD_TYPE;
    end else if (8'(running_sum + rx_byte) != 8'd0) begin
      status_next = ST_BAD_SUM;
    end else if (frame_type == TYPE_UPLOAD) begin
      upload_next = 1'b1;
      conc_next   = {payload[2], payload[3]};
    end else begin
      conc_next = {payload[0], payload[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HUNT;
      running_sum <= 8'd0;
      frame_type  <= 8'd0;
    end else if (in_fire) begin
      pos         <= pos_next;
      running_sum <= running_sum_next;
      if (pos == POS_TYPE) begin
        frame_type <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && pos >= POS_FIRST_DATA && pos <= POS_LAST_DATA) begin
      payload[pay_idx] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status        <= status_next;
      concentration <= conc_next;
      active_upload <= upload_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= FRAME_LAST)
    else $error("Frame position left the frame range.");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && pos == FRAME_LAST |=> out_valid)
    else $error("Checksum byte did not produce a result.");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !(in_valid && in_ready && pos == FRAME_LAST) |=> !out_valid)
    else $error("Result register held a beat that had been taken.");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> concentration == 16'd0 && !active_upload)
    else $error("Failed frame carried a reading.");
`endif

endmodule
